[rtl/core/pfps_pkg.sv]
// Shared widths, register indexes and the job record for the packed FFT
// power spectrum block. No dependencies.
package pfps_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int MAX_FFT_LOG2 = 12;
    localparam int MIN_FFT_LOG2 = 4;
    localparam int PAIR_BITS    = 11;
    localparam int BIN_BITS     = 12;
    localparam int VALUE_BITS   = 48;
    localparam int POWER_BITS   = 2 * SAMPLE_BITS;
    localparam int ROOT_BITS    = SAMPLE_BITS;
    localparam int LOG_BITS     = 22;
    localparam int FRAC_STEPS   = 30;
    localparam int ISQRT_STAGES = ROOT_BITS;
    localparam int LOG_STAGES   = FRAC_STEPS + 5;
    localparam int ROOT_PAD     = LOG_STAGES - ISQRT_STAGES;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = 4;

    localparam logic [26:0] LN2_Q27 = 27'd93032640;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FFT_SIZE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POWER_MODE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOG_MODE   = 2'd2;

    typedef struct packed {
        logic                   valid;
        logic [BIN_BITS-1:0]    bin;
        logic                   last;
        logic [SAMPLE_BITS-1:0] mag_a;
        logic [SAMPLE_BITS-1:0] mag_b;
    } job_t;

endpackage

[rtl/core/packed_fft_power_spectrum.sv]
// Packed real FFT frame to power, magnitude or log spectrum: one pair in per
// cycle while the output is not stalled; pair 0 yields bin 0 and bin N/2 and
// holds the input while its Nyquist job is issued. Results pass a delay line
// matched to the 30-step log2 squaring chain. A stalled output stalls the
// whole pipeline. Depends on pfps_pkg, pfps_front, pfps_isqrt, pfps_log.
module packed_fft_power_spectrum (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [pfps_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [pfps_pkg::CFG_BITS-1:0]           cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [pfps_pkg::PAIR_BITS-1:0]          pair_index,
    input  logic signed [pfps_pkg::SAMPLE_BITS-1:0] first_value,
    input  logic signed [pfps_pkg::SAMPLE_BITS-1:0] second_value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [pfps_pkg::BIN_BITS-1:0]           bin_index,
    output logic [pfps_pkg::VALUE_BITS-1:0]         bin_value,
    output logic                                    log_of_zero,
    output logic                                    frame_last
);

    localparam int L  = pfps_pkg::LOG_STAGES;
    localparam int BB = pfps_pkg::BIN_BITS;
    localparam int PB = pfps_pkg::POWER_BITS;
    localparam int RP = pfps_pkg::ROOT_PAD;

    logic [3:0] fft_log_reg;
    logic       power_mode_reg, log_mode_reg;
    logic [3:0] lg_eff;
    logic [BB-1:0] pairs;
    logic       en;

    pfps_pkg::job_t job;

    logic          s1_valid_reg, s1_last_reg, s2_valid_reg, s2_last_reg;
    logic [BB-1:0] s1_bin_reg, s2_bin_reg;
    logic [PB-1:0] sq_a_reg, sq_b_reg, power_reg;

    logic          line_valid_reg [L];
    logic          line_last_reg  [L];
    logic [BB-1:0] line_bin_reg   [L];
    logic [PB-1:0] line_power_reg [L];

    logic [pfps_pkg::ROOT_BITS-1:0] root, root_pad_reg [RP];
    logic [pfps_pkg::LOG_BITS-1:0]  ln_value;

    logic                            out_valid_reg, zero_reg, last_reg;
    logic [BB-1:0]                   bin_reg;
    logic [pfps_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic                            is_zero;

    // the whole pipeline advances unless a held result is refused
    assign en = !out_valid_reg || !out_stall;

    always_comb
    begin
        lg_eff = fft_log_reg;
        if (fft_log_reg < 4'(pfps_pkg::MIN_FFT_LOG2))
            lg_eff = 4'(pfps_pkg::MIN_FFT_LOG2);
        else if (fft_log_reg > 4'(pfps_pkg::MAX_FFT_LOG2))
            lg_eff = 4'(pfps_pkg::MAX_FFT_LOG2);
    end
    assign pairs = BB'(1) << (lg_eff - 4'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fft_log_reg    <= 4'd9;
            power_mode_reg <= 1'b1;
            log_mode_reg   <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                pfps_pkg::CFG_FFT_SIZE:   fft_log_reg    <= cfg_data;
                pfps_pkg::CFG_POWER_MODE: power_mode_reg <= cfg_data[0];
                pfps_pkg::CFG_LOG_MODE:   log_mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    pfps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .pairs        (pairs),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pair_index   (pair_index),
        .first_value  (first_value),
        .second_value (second_value),
        .job          (job)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < L; i++)
                line_valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg      <= job.valid;
            s2_valid_reg      <= s1_valid_reg;
            line_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < L; i++)
                line_valid_reg[i] <= line_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_bin_reg        <= job.bin;
            s1_last_reg       <= job.last;
            sq_a_reg          <= job.mag_a * job.mag_a;
            sq_b_reg          <= job.mag_b * job.mag_b;
            s2_bin_reg        <= s1_bin_reg;
            s2_last_reg       <= s1_last_reg;
            power_reg         <= sq_a_reg + sq_b_reg;
            line_bin_reg[0]   <= s2_bin_reg;
            line_last_reg[0]  <= s2_last_reg;
            line_power_reg[0] <= power_reg;
            for (int i = 1; i < L; i++)
            begin
                line_bin_reg[i]   <= line_bin_reg[i-1];
                line_last_reg[i]  <= line_last_reg[i-1];
                line_power_reg[i] <= line_power_reg[i-1];
            end
            root_pad_reg[0] <= root;
            for (int i = 1; i < RP; i++)
                root_pad_reg[i] <= root_pad_reg[i-1];
        end
    end

    pfps_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .x    (power_reg),
        .root (root)
    );

    pfps_log u_log (
        .clk        (clk),
        .en         (en),
        .power_mode (power_mode_reg),
        .x          (power_reg),
        .ln_value   (ln_value)
    );

    assign is_zero = log_mode_reg && (line_power_reg[L-1] == '0);

    always_comb
    begin
        if (log_mode_reg)
            value_next = is_zero ? '0 : pfps_pkg::VALUE_BITS'(ln_value);
        else if (power_mode_reg)
            value_next = pfps_pkg::VALUE_BITS'(line_power_reg[L-1]);
        else
            value_next = pfps_pkg::VALUE_BITS'(root_pad_reg[RP-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= line_valid_reg[L-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bin_reg   <= line_bin_reg[L-1];
            last_reg  <= line_last_reg[L-1];
            zero_reg  <= is_zero;
            value_reg <= value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bin_index   = bin_reg;
    assign bin_value   = value_reg;
    assign log_of_zero = zero_reg;
    assign frame_last  = last_reg;

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output is blocked");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && log_of_zero) |-> (bin_value == '0))
        else $error("log of zero with nonzero value");

    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> (bin_index != '0))
        else $error("frame_last on bin 0");

    a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !log_mode_reg) |-> !log_of_zero)
        else $error("log_of_zero outside log mode");

endmodule

[rtl/core/pfps_front.sv]
// Input stage: range check, absolute values, and the split of pair 0 into
// its DC and Nyquist jobs. Depends on pfps_pkg.
module pfps_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic [pfps_pkg::BIN_BITS-1:0]         pairs,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [pfps_pkg::PAIR_BITS-1:0]        pair_index,
    input  logic signed [pfps_pkg::SAMPLE_BITS-1:0] first_value,
    input  logic signed [pfps_pkg::SAMPLE_BITS-1:0] second_value,
    output pfps_pkg::job_t                        job
);

    logic                             hold_reg, hold_next;
    logic [pfps_pkg::SAMPLE_BITS-1:0] nyq_reg, nyq_next;
    pfps_pkg::job_t                   job_reg, job_next;
    logic [pfps_pkg::SAMPLE_BITS-1:0] fv, sv, abs_a, abs_b;
    logic [pfps_pkg::BIN_BITS-1:0]    pidx;
    logic                             accept;

    assign in_stall = !en || hold_reg;
    assign accept   = in_valid && !in_stall;
    assign fv       = first_value;
    assign sv       = second_value;
    assign abs_a    = fv[pfps_pkg::SAMPLE_BITS-1] ? (~fv + 1'b1) : fv;
    assign abs_b    = sv[pfps_pkg::SAMPLE_BITS-1] ? (~sv + 1'b1) : sv;
    assign pidx     = {1'b0, pair_index};
    assign job      = job_reg;

    always_comb
    begin
        hold_next = hold_reg;
        nyq_next  = nyq_reg;
        job_next  = job_reg;
        if (en)
        begin
            job_next.valid = 1'b0;
            if (hold_reg)
            begin
                // second half of pair 0: Nyquist bin
                job_next.valid = 1'b1;
                job_next.bin   = pairs;
                job_next.last  = 1'b0;
                job_next.mag_a = nyq_reg;
                job_next.mag_b = '0;
                hold_next      = 1'b0;
            end
            else if (accept && (pidx < pairs))
            begin
                job_next.valid = 1'b1;
                job_next.bin   = pidx;
                job_next.mag_a = abs_a;
                if (pair_index == '0)
                begin
                    job_next.last  = 1'b0;
                    job_next.mag_b = '0;
                    hold_next      = 1'b1;
                    nyq_next       = abs_b;
                end
                else
                begin
                    job_next.last  = (pidx == pfps_pkg::BIN_BITS'(pairs - 1'b1));
                    job_next.mag_b = abs_b;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            job_reg  <= '0;
        end
        else
        begin
            hold_reg <= hold_next;
            job_reg  <= job_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nyq_reg <= nyq_next;
    end

endmodule

[rtl/core/pfps_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Depends on pfps_pkg.
module pfps_isqrt (
    input  logic                            clk,
    input  logic                            en,
    input  logic [pfps_pkg::POWER_BITS-1:0] x,
    output logic [pfps_pkg::ROOT_BITS-1:0]  root
);

    localparam int REM_BITS = pfps_pkg::ROOT_BITS + 3;
    localparam int N        = pfps_pkg::ISQRT_STAGES;
    localparam int PB       = pfps_pkg::POWER_BITS;
    localparam int RB       = pfps_pkg::ROOT_BITS;

    logic [REM_BITS-1:0] rem_reg  [N];
    logic [RB-1:0]       root_reg [N];
    logic [PB-1:0]       xs_reg   [N];

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        logic [REM_BITS-1:0] rem_in, cand, trial, rem_out;
        logic [RB-1:0]       root_in, root_out;
        logic [PB-1:0]       x_in;

        if (g == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = x;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign x_in    = xs_reg[g-1];
        end

        always_comb
        begin
            cand  = {rem_in[REM_BITS-3:0], x_in[PB-1 -: 2]};
            trial = {1'b0, root_in, 2'b01};
            if (cand >= trial)
            begin
                rem_out  = cand - trial;
                root_out = {root_in[RB-2:0], 1'b1};
            end
            else
            begin
                rem_out  = cand;
                root_out = {root_in[RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_out;
                root_reg[g] <= root_out;
                xs_reg[g]   <= {x_in[PB-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

[rtl/core/pfps_log.sv]
// Pipelined natural log in Q.16, halved when power_mode is low: normalize,
// 30 squaring stages for the log2 fraction, multiply by ln2, round. Depends on pfps_pkg.
module pfps_log (
    input  logic                            clk,
    input  logic                            en,
    input  logic                            power_mode,
    input  logic [pfps_pkg::POWER_BITS-1:0] x,
    output logic [pfps_pkg::LOG_BITS-1:0]   ln_value
);

    localparam int PB = pfps_pkg::POWER_BITS;
    localparam int FS = pfps_pkg::FRAC_STEPS;
    localparam logic [26:0] LN2 = pfps_pkg::LN2_Q27;

    logic [PB-1:0] n1_x_reg;
    logic [5:0]    n1_lz_reg;
    logic [PB-1:0] t1, t2;
    logic [5:0]    lz1, lz2;
    logic [31:0]   n2_m_reg;
    logic [5:0]    n2_e_reg;

    logic [31:0]   m_reg    [FS];
    logic [FS-1:0] frac_reg [FS];
    logic [5:0]    e_reg    [FS];

    logic [44:0]   p_hi_reg, p_lo_reg;
    logic [62:0]   p_reg;
    logic [35:0]   lg2;
    logic [63:0]   rnd;
    logic [pfps_pkg::LOG_BITS-1:0] ln_reg;

    // coarse leading-zero shift
    always_comb
    begin
        t1  = x;
        lz1 = '0;
        if (t1[PB-1 -: 32] == '0)
        begin
            t1  = {t1[PB-33:0], 32'd0};
            lz1 = lz1 + 6'd32;
        end
        if (t1[PB-1 -: 16] == '0)
        begin
            t1  = {t1[PB-17:0], 16'd0};
            lz1 = lz1 + 6'd16;
        end
        if (t1[PB-1 -: 8] == '0)
        begin
            t1  = {t1[PB-9:0], 8'd0};
            lz1 = lz1 + 6'd8;
        end
    end

    // fine leading-zero shift
    always_comb
    begin
        t2  = n1_x_reg;
        lz2 = n1_lz_reg;
        if (t2[PB-1 -: 4] == '0)
        begin
            t2  = {t2[PB-5:0], 4'd0};
            lz2 = lz2 + 6'd4;
        end
        if (t2[PB-1 -: 2] == '0)
        begin
            t2  = {t2[PB-3:0], 2'd0};
            lz2 = lz2 + 6'd2;
        end
        if (t2[PB-1] == 1'b0)
        begin
            t2  = {t2[PB-2:0], 1'b0};
            lz2 = lz2 + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_x_reg  <= t1;
            n1_lz_reg <= lz1;
            n2_m_reg  <= t2[PB-1 -: 32];
            n2_e_reg  <= 6'(PB - 1) - lz2;
        end
    end

    for (genvar k = 0; k < FS; k++)
    begin : g_sq
        logic [31:0]   m_in, m_out;
        logic [FS-1:0] f_in;
        logic [5:0]    e_in;
        logic [63:0]   sq;
        logic [32:0]   s;

        if (k == 0)
        begin : g_first
            assign m_in = n2_m_reg;
            assign f_in = '0;
            assign e_in = n2_e_reg;
        end
        else
        begin : g_next
            assign m_in = m_reg[k-1];
            assign f_in = frac_reg[k-1];
            assign e_in = e_reg[k-1];
        end

        assign sq    = m_in * m_in;
        assign s     = sq[63:31];
        // halve when the square reaches 2.0 and set the fraction bit
        assign m_out = s[32] ? s[32:1] : s[31:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[k]    <= m_out;
                frac_reg[k] <= {f_in[FS-2:0], s[32]};
                e_reg[k]    <= e_in;
            end
        end
    end

    assign lg2 = {e_reg[FS-1], frac_reg[FS-1]};
    assign rnd = power_mode ? ({1'b0, p_reg} + (64'd1 << 40)) >> 41
                            : ({1'b0, p_reg} + (64'd1 << 41)) >> 42;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_hi_reg <= lg2[35:18] * LN2;
            p_lo_reg <= lg2[17:0] * LN2;
            p_reg    <= {p_hi_reg, 18'd0} + {18'd0, p_lo_reg};
            ln_reg   <= pfps_pkg::LOG_BITS'(rnd);
        end
    end

    assign ln_value = ln_reg;

endmodule
